[design/assert_macros.svh]
// assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clk edge outside reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kvwb_pkg.sv]
// shared types and constants of the write batch record parser
package kvwb_pkg;

  // header layout
  localparam int HDR_BYTES    = 12;
  localparam int COUNT_OFFSET = 8;

  // result queue between parser and output stage
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic CFG_PUT_TAG = 1'b0;
  localparam logic CFG_DEL_TAG = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_TAG    = 3'd1,
    PH_KEYLEN = 3'd2,
    PH_KEY    = 3'd3,
    PH_VALLEN = 3'd4,
    PH_VALUE  = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_KEY       = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_EMPTY_KEY = 3'd2,
    KIND_EMPTY_VAL = 3'd3,
    KIND_STATUS    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SMALL  = 3'd1,
    ST_BADPUT = 3'd2,
    ST_BADDEL = 3'd3,
    ST_BADTAG = 3'd4,
    ST_COUNT  = 3'd5
  } status_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        flast;
    logic        rdel;
    logic [63:0] rseq;
    logic        done;
    status_t     status;
  } res_t;

endpackage

[design/kvwb_front.sv]
// front part: takes batch bytes, tracks the parse phase, builds result words
module kvwb_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      batch_byte,
  input  logic            batch_last,
  input  logic            q_full,
  output logic            push,
  output kvwb_pkg::res_t  push_word
);
  import kvwb_pkg::*;

  `include "assert_macros.svh"

  logic [7:0]  put_tag_code;
  logic [7:0]  delete_tag_code;

  phase_t      phase;
  logic [3:0]  header_index;
  logic [63:0] start_sequence;
  logic [31:0] expected_count;
  logic [31:0] found_count;
  logic [31:0] length_accum;
  logic [2:0]  length_byte_index;
  logic [31:0] bytes_remaining;
  logic [63:0] current_sequence;
  logic        current_is_delete;
  status_t     first_error;

  phase_t      phase_next;
  logic [3:0]  header_index_next;
  logic [63:0] start_sequence_next;
  logic [31:0] expected_count_next;
  logic [31:0] found_count_next;
  logic [31:0] length_accum_next;
  logic [2:0]  length_byte_index_next;
  logic [31:0] bytes_remaining_next;
  logic [63:0] current_sequence_next;
  logic        current_is_delete_next;
  status_t     first_error_next;

  logic        accept;
  logic        tag_put;
  logic        tag_del;
  logic [2:0]  vidx;
  logic [31:0] vshift;
  logic [31:0] vacc;
  logic        vbad;
  logic        vdone;
  logic [31:0] rem_dec;
  logic        rem_zero;
  logic        hdr_end;
  logic        in_record;
  logic        rec_finish;
  logic        have;
  res_t        word;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      put_tag_code    <= 8'd1;
      delete_tag_code <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PUT_TAG: put_tag_code <= cfg_data;
        CFG_DEL_TAG: delete_tag_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte decode: tag match, varint digit, field countdown
  assign tag_put  = (batch_byte == put_tag_code);
  assign tag_del  = !tag_put && (batch_byte == delete_tag_code);
  assign vidx     = (length_byte_index > 3'd4) ? 3'd4 : length_byte_index;
  assign vacc     = length_accum | vshift;
  assign vbad     = batch_byte[7] && (vidx == 3'd4);
  assign vdone    = !batch_byte[7];
  assign rem_dec  = bytes_remaining - 32'd1;
  assign rem_zero = (rem_dec == 32'd0);
  assign hdr_end  = (header_index >= 4'(HDR_BYTES - 1));

  // place the seven payload bits of a varint byte, bits past 32 dropped
  always_comb begin
    case (vidx)
      3'd0:    vshift = {25'd0, batch_byte[6:0]};
      3'd1:    vshift = {18'd0, batch_byte[6:0], 7'd0};
      3'd2:    vshift = {11'd0, batch_byte[6:0], 14'd0};
      3'd3:    vshift = {4'd0, batch_byte[6:0], 21'd0};
      default: vshift = {batch_byte[3:0], 28'd0};
    endcase
  end

  // next phase for the accepted byte, before the end-of-batch clear
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HEADER: if (hdr_end) phase_next = PH_TAG;
      PH_TAG: begin
        if (tag_put || tag_del) phase_next = PH_KEYLEN;
        else phase_next = PH_ERROR;
      end
      PH_KEYLEN, PH_VALLEN: begin
        if (vbad) begin
          phase_next = PH_ERROR;
        end else if (vdone) begin
          if (vacc == 32'd0) begin
            if (phase == PH_KEYLEN && !current_is_delete) phase_next = PH_VALLEN;
            else phase_next = PH_TAG;
          end else begin
            phase_next = (phase == PH_KEYLEN) ? PH_KEY : PH_VALUE;
          end
        end
      end
      PH_KEY, PH_VALUE: begin
        if (rem_zero) begin
          if (phase == PH_KEY && !current_is_delete) phase_next = PH_VALLEN;
          else phase_next = PH_TAG;
        end
      end
      PH_ERROR: phase_next = PH_ERROR;
      default:  phase_next = PH_ERROR;
    endcase
  end

  assign in_record  = (phase == PH_KEYLEN) || (phase == PH_KEY) ||
                      (phase == PH_VALLEN) || (phase == PH_VALUE);
  assign rec_finish = in_record && (phase_next == PH_TAG);

  // datapath next values
  always_comb begin
    header_index_next      = header_index;
    start_sequence_next    = start_sequence;
    expected_count_next    = expected_count;
    found_count_next       = found_count;
    length_accum_next      = length_accum;
    length_byte_index_next = length_byte_index;
    bytes_remaining_next   = bytes_remaining;
    current_sequence_next  = current_sequence;
    current_is_delete_next = current_is_delete;
    first_error_next       = first_error;
    case (phase)
      PH_HEADER: begin
        header_index_next = header_index + 4'd1;
        if (!header_index[3]) begin
          start_sequence_next = start_sequence |
                                ({56'd0, batch_byte} << {header_index[2:0], 3'b000});
        end else if (header_index < 4'(HDR_BYTES)) begin
          expected_count_next = expected_count |
                                ({24'd0, batch_byte} << {header_index[1:0], 3'b000});
        end
        if (hdr_end) current_sequence_next = start_sequence;
      end
      PH_TAG: begin
        found_count_next       = found_count + 32'd1;
        length_accum_next      = 32'd0;
        length_byte_index_next = 3'd0;
        if (tag_put) current_is_delete_next = 1'b0;
        else if (tag_del) current_is_delete_next = 1'b1;
        else first_error_next = ST_BADTAG;
      end
      PH_KEYLEN, PH_VALLEN: begin
        length_accum_next = vacc;
        if (vbad) begin
          first_error_next = current_is_delete ? ST_BADDEL : ST_BADPUT;
        end else if (!vdone) begin
          length_byte_index_next = vidx + 3'd1;
        end else begin
          length_accum_next      = 32'd0;
          length_byte_index_next = 3'd0;
          bytes_remaining_next   = vacc;
        end
      end
      PH_KEY, PH_VALUE: bytes_remaining_next = rem_dec;
      default: ;
    endcase
    if (rec_finish) current_sequence_next = current_sequence + 64'd1;
  end

  // result word for the accepted byte
  always_comb begin
    have           = 1'b0;
    word.kind      = KIND_KEY;
    word.data      = 8'd0;
    word.flast     = 1'b0;
    word.rdel      = 1'b0;
    word.rseq      = 64'd0;
    word.done      = 1'b0;
    word.status    = ST_OK;
    case (phase)
      PH_KEYLEN, PH_VALLEN: begin
        if (!vbad && vdone && vacc == 32'd0) begin
          have      = 1'b1;
          word.kind = (phase == PH_KEYLEN) ? KIND_EMPTY_KEY : KIND_EMPTY_VAL;
          word.rdel = current_is_delete;
          word.rseq = current_sequence;
        end
      end
      PH_KEY, PH_VALUE: begin
        have       = 1'b1;
        word.kind  = (phase == PH_KEY) ? KIND_KEY : KIND_VALUE;
        word.data  = batch_byte;
        word.flast = rem_zero;
        word.rdel  = current_is_delete;
        word.rseq  = current_sequence;
      end
      default: ;
    endcase
    // closing byte of the batch reports status
    if (batch_last) begin
      word.done = 1'b1;
      if (phase_next == PH_ERROR) word.status = first_error_next;
      else if (phase_next == PH_HEADER) word.status = ST_SMALL;
      else if (phase_next != PH_TAG)
        word.status = current_is_delete_next ? ST_BADDEL : ST_BADPUT;
      else if (found_count_next == expected_count_next) word.status = ST_OK;
      else word.status = ST_COUNT;
      if (!have) begin
        word.kind = KIND_STATUS;
        word.data = 8'd0;
        word.flast = 1'b0;
        word.rdel = 1'b0;
        word.rseq = 64'd0;
      end
    end
  end

  assign push      = accept && (have || batch_last);
  assign push_word = word;

  // parse state, cleared at the end of each batch
  always_ff @(posedge clk) begin
    if (rst || (accept && batch_last)) begin
      phase             <= PH_HEADER;
      header_index      <= 4'd0;
      start_sequence    <= 64'd0;
      expected_count    <= 32'd0;
      found_count       <= 32'd0;
      length_accum      <= 32'd0;
      length_byte_index <= 3'd0;
      bytes_remaining   <= 32'd0;
      current_sequence  <= 64'd0;
      current_is_delete <= 1'b0;
      first_error       <= ST_OK;
    end else if (accept) begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      start_sequence    <= start_sequence_next;
      expected_count    <= expected_count_next;
      found_count       <= found_count_next;
      length_accum      <= length_accum_next;
      length_byte_index <= length_byte_index_next;
      bytes_remaining   <= bytes_remaining_next;
      current_sequence  <= current_sequence_next;
      current_is_delete <= current_is_delete_next;
      first_error       <= first_error_next;
    end
  end

  `ASSERT_NEXT(a_last_clears, accept && batch_last,
    phase == PH_HEADER && header_index == 4'd0 && found_count == 32'd0,
    "parse state not cleared after last byte")
  `ASSERT_NOW(a_status_only_done, push && push_word.kind == KIND_STATUS,
    push_word.done, "status-only word without batch close")
  `ASSERT_NOW(a_status_needs_done, push && !push_word.done,
    push_word.status == ST_OK, "status reported before batch close")
  `ASSERT_NOW(a_push_needs_room, push, !q_full, "word pushed into full queue")

endmodule

[design/kvwb_queue.sv]
// short result queue between the parser and the output stage
module kvwb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kvwb_pkg::res_t  push_word,
  output logic            full,
  output logic            head_valid,
  output kvwb_pkg::res_t  head_word,
  input  logic            pop
);
  import kvwb_pkg::*;

  `include "assert_macros.svh"

  res_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_word;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + Q_CNT_W'(1);
      else if (pop && !push) count <= count - Q_CNT_W'(1);
    end
  end

  `ASSERT_NOW(a_count_bound, 1'b1, count <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
  `ASSERT_NOW(a_no_pop_empty, pop, head_valid, "pop from empty queue")
  `ASSERT_NEXT(a_push_lands, push && !pop && !full, head_valid,
    "pushed word not visible")

endmodule

[design/kvwb_back.sv]
// back part: output register that hands result words to the consumer
module kvwb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  kvwb_pkg::res_t  head_word,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output kvwb_pkg::res_t  out_word
);
  import kvwb_pkg::*;

  res_t hold;

  // load a new word when the register is empty or being taken
  assign pop      = head_valid && (!out_valid || out_ready);
  assign out_word = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) hold <= head_word;
  end

endmodule

[design/kv_write_batch_record_parser_unit.sv]
// top level of the write batch record parser
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | batch_byte, batch_last
//  output   | out_valid / out_ready| item_kind, data_byte, field_last,
//           |                      | record_is_delete, record_sequence,
//           |                      | batch_done, status
//  config   | cfg_write            | cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; each byte is parsed in the cycle it is taken.
// A result word passes through the queue and then the output register before it
// shows on out_valid; the load waits while the register holds an untaken word.
// Synchronous reset returns the parser to the header phase; no clearing pass.
// A two-word queue sits between parser and output register; in_ready drops
// only while the queue holds two words.
module kv_write_batch_record_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  batch_byte,
  input  logic        batch_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  item_kind,
  output logic [7:0]  data_byte,
  output logic        field_last,
  output logic        record_is_delete,
  output logic [63:0] record_sequence,
  output logic        batch_done,
  output logic [2:0]  status
);
  import kvwb_pkg::*;

  logic push;
  res_t push_word;
  logic q_full;
  logic head_valid;
  res_t head_word;
  logic pop;
  res_t out_word;

  // parser
  kvwb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .batch_byte (batch_byte),
    .batch_last (batch_last),
    .q_full     (q_full),
    .push       (push),
    .push_word  (push_word)
  );

  // result queue
  kvwb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop)
  );

  // output register
  kvwb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  assign item_kind        = out_word.kind;
  assign data_byte        = out_word.data;
  assign field_last       = out_word.flast;
  assign record_is_delete = out_word.rdel;
  assign record_sequence  = out_word.rseq;
  assign batch_done       = out_word.done;
  assign status           = out_word.status;

endmodule
